[hw/rtl/ascii_string_to_integer_parser_unit_macros.svh]
// Assertion macros for the ASCII string to integer parser.
// Used by the top level; the macros expect i_clk and i_rst_n in scope.
`ifndef ASCII_STRING_TO_INTEGER_PARSER_UNIT_MACROS_SVH
`define ASCII_STRING_TO_INTEGER_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASIP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASIP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/asip_pkg.sv]
// Shared types, constants and helper functions of the ASCII string parser.
// No dependencies; used by the interfaces and the top level.
`timescale 1ns / 1ps

package asip_pkg;

    // Width of the running total and of the result value field.
    localparam int VALUE_BITS   = 32;
    localparam int RESULT_BITS  = 32;
    localparam int CHAR_BITS    = 8;
    localparam int RADIX_BITS   = 5;
    localparam int DIGIT_BITS   = 6;

    // Character codes.
    localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CHAR_BITS-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_LO_B  = 8'h62;
    localparam logic [CHAR_BITS-1:0] CH_LO_O  = 8'h6F;
    localparam logic [CHAR_BITS-1:0] CH_LO_X  = 8'h78;
    localparam logic [CHAR_BITS-1:0] CH_LO_Z  = 8'h7A;

    // Radix codes.
    localparam logic [RADIX_BITS-1:0] RADIX_AUTO = 5'd0;
    localparam logic [RADIX_BITS-1:0] RADIX_2    = 5'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_8    = 5'd8;
    localparam logic [RADIX_BITS-1:0] RADIX_10   = 5'd10;
    localparam logic [RADIX_BITS-1:0] RADIX_16   = 5'd16;

    // Digit value that no base accepts.
    localparam logic [DIGIT_BITS-1:0] DIGIT_NONE = 6'd63;

    // Status codes.
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_RADIX = 1'b1;

    // Parse phase, one-hot.
    typedef enum logic [4:0] {
        PH_SKIP   = 5'b00001,
        PH_SIGNED = 5'b00010,
        PH_ZERO   = 5'b00100,
        PH_DIGITS = 5'b01000,
        PH_DONE   = 5'b10000
    } t_phase;

    // True for the bases the parser supports, automatic detection included.
    function automatic logic radix_ok(input logic [RADIX_BITS-1:0] r);
        return (r == RADIX_AUTO) || (r == RADIX_2) || (r == RADIX_8) ||
               (r == RADIX_10) || (r == RADIX_16);
    endfunction

    // Digit value of a character, or DIGIT_NONE if it is no digit at all.
    function automatic logic [DIGIT_BITS-1:0] digit_of(input logic [CHAR_BITS-1:0] c);
        logic [CHAR_BITS-1:0] t;
        t = CH_NUL;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            t = c - CH_ZERO;
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            t = c - CH_UP_A + 8'd10;
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            t = c - CH_LO_A + 8'd10;
        end else begin
            t = {2'b00, DIGIT_NONE};
        end
        return t[DIGIT_BITS-1:0];
    endfunction

endpackage

[hw/rtl/asip_char_if.sv]
// Character channel: one string byte per transaction with valid/ready.
// Depends on asip_pkg.
`timescale 1ns / 1ps

interface asip_char_if import asip_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CHAR_BITS-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

[hw/rtl/asip_result_if.sv]
// Result channel: parsed value and status per transaction with valid/ready.
// Depends on asip_pkg.
`timescale 1ns / 1ps

interface asip_result_if import asip_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [RESULT_BITS-1:0] parsed_value;
    logic                   status_code;

    modport source (output valid, output parsed_value, output status_code, input ready);
    modport sink   (input valid, input parsed_value, input status_code, output ready);
endinterface

[hw/rtl/ascii_string_to_integer_parser_unit.sv]
// ASCII string to integer parser top level; depends on asip_pkg, the interfaces and macros.
// Latency: the result is valid in the cycle after the terminating zero byte is accepted.
// Throughput: one byte per cycle; the result register decouples input from output stalls,
// and a byte is refused only while a result waits and the receiver is not ready.
// Reset (synchronous, active low) clears the radix register, the parse state and
// the result valid flag; bytes are accepted from the first cycle after release.
`timescale 1ns / 1ps
`include "ascii_string_to_integer_parser_unit_macros.svh"

module ascii_string_to_integer_parser_unit import asip_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [RADIX_BITS-1:0] i_cfg_wr_data,
    asip_char_if.sink             i_char,
    asip_result_if.source         o_result
);

    // Configuration and parse state.
    logic [RADIX_BITS-1:0]  r_radix_select;
    t_phase                 r_phase, n_phase;
    logic                   r_minus, n_minus;
    logic [RADIX_BITS-1:0]  r_active_radix, n_active_radix;
    logic [VALUE_BITS-1:0]  r_total, n_total;

    // Result register.
    logic                   r_out_valid;
    logic [RESULT_BITS-1:0] r_out_value, n_out_value;
    logic                   r_out_status, n_out_status;

    // Datapath signals.
    logic                   in_accept;
    logic                   is_term;
    logic                   is_blank;
    logic [RADIX_BITS-1:0]  eff_radix;
    logic [RADIX_BITS-1:0]  dig_radix;
    logic [DIGIT_BITS-1:0]  digit;
    logic                   digit_ok;
    logic [VALUE_BITS-1:0]  mac_total;
    logic [VALUE_BITS-1:0]  signed_total;

    // Handshake: take a byte whenever the result register can hold a new result.
    assign i_char.ready = !r_out_valid || o_result.ready;
    assign in_accept    = i_char.valid && i_char.ready;

    assign o_result.valid        = r_out_valid;
    assign o_result.parsed_value = r_out_value;
    assign o_result.status_code  = r_out_status;

    // Radix is sampled from the register throughout the blank phase.
    assign eff_radix = (r_phase == PH_SKIP) ? r_radix_select : r_active_radix;
    assign dig_radix = (eff_radix == RADIX_AUTO) ? RADIX_10 : eff_radix;

    assign is_term  = (i_char.char_code == CH_NUL);
    assign is_blank = (i_char.char_code <= CH_SPACE) || i_char.char_code[CHAR_BITS-1];

    // Digit decode and multiply-accumulate by shift-add for the supported bases.
    assign digit    = digit_of(i_char.char_code);
    assign digit_ok = ({1'b0, digit} < {{(DIGIT_BITS+1-RADIX_BITS){1'b0}}, dig_radix});

    always_comb begin
        case (dig_radix)
            RADIX_2:  mac_total = (r_total << 1) + VALUE_BITS'(digit);
            RADIX_8:  mac_total = (r_total << 3) + VALUE_BITS'(digit);
            RADIX_16: mac_total = (r_total << 4) + VALUE_BITS'(digit);
            default:  mac_total = (r_total << 3) + (r_total << 1) + VALUE_BITS'(digit);
        endcase
    end

    assign signed_total = r_minus ? (~r_total + 1'b1) : r_total;

    // Next parse state for the byte on the input channel.
    always_comb begin
        n_phase        = r_phase;
        n_minus        = r_minus;
        n_active_radix = eff_radix;
        n_total        = r_total;
        n_out_value    = '0;
        n_out_status   = STATUS_OK;

        if (is_term) begin
            if (radix_ok(eff_radix)) begin
                n_out_value  = RESULT_BITS'(signed_total);
                n_out_status = STATUS_OK;
            end else begin
                n_out_value  = '0;
                n_out_status = STATUS_BAD_RADIX;
            end
            n_phase        = PH_SKIP;
            n_minus        = 1'b0;
            n_active_radix = RADIX_AUTO;
            n_total        = '0;
        end else begin
            unique case (r_phase) inside
                PH_SKIP, PH_SIGNED: begin
                    if (r_phase == PH_SKIP && is_blank) begin
                        n_phase = PH_SKIP;
                    end else if (r_phase == PH_SKIP && !radix_ok(eff_radix)) begin
                        n_phase = PH_DONE;
                    end else if (r_phase == PH_SKIP && i_char.char_code == CH_PLUS) begin
                        n_phase = PH_SIGNED;
                    end else if (r_phase == PH_SKIP && i_char.char_code == CH_MINUS) begin
                        n_minus = 1'b1;
                        n_phase = PH_SIGNED;
                    end else if (eff_radix == RADIX_AUTO && i_char.char_code == CH_ZERO) begin
                        // Leading zero may open a base prefix.
                        n_total = '0;
                        n_phase = PH_ZERO;
                    end else begin
                        n_active_radix = dig_radix;
                        if (digit_ok) begin
                            n_total = mac_total;
                            n_phase = PH_DIGITS;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                end
                PH_ZERO: begin
                    if (i_char.char_code == CH_LO_B) begin
                        n_active_radix = RADIX_2;
                        n_phase        = PH_DIGITS;
                    end else if (i_char.char_code == CH_LO_O) begin
                        n_active_radix = RADIX_8;
                        n_phase        = PH_DIGITS;
                    end else if (i_char.char_code == CH_LO_X) begin
                        n_active_radix = RADIX_16;
                        n_phase        = PH_DIGITS;
                    end else begin
                        n_active_radix = RADIX_10;
                        if (digit_ok) begin
                            n_total = mac_total;
                            n_phase = PH_DIGITS;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                end
                PH_DIGITS: begin
                    if (digit_ok) begin
                        n_total = mac_total;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
        end
    end

    // Radix configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix_select <= RADIX_AUTO;
        end else if (i_cfg_wr_en) begin
            r_radix_select <= i_cfg_wr_data;
        end
    end

    // Parse state advances on every accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_SKIP;
            r_minus        <= 1'b0;
            r_active_radix <= RADIX_AUTO;
            r_total        <= '0;
        end else if (in_accept) begin
            r_phase        <= n_phase;
            r_minus        <= n_minus;
            r_active_radix <= n_active_radix;
            r_total        <= n_total;
        end
    end

    // Result register: loaded by the terminating byte, emptied when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && is_term) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && is_term) begin
            r_out_value  <= n_out_value;
            r_out_status <= n_out_status;
        end
    end

    // Checks on the parse logic.
    `ASIP_ASSERT_NOW(a_bad_zero, r_out_valid && r_out_status, r_out_value == '0, "bad value")
    `ASIP_ASSERT_NEXT(a_rearm, in_accept && is_term, r_out_valid && (r_phase == PH_SKIP), "no rearm")
    `ASIP_ASSERT_NOW(a_ready, !r_out_valid, i_char.ready, "input stalled with empty output")

endmodule

[tb/ascii_string_to_integer_parser_unit_test.sv]
`timescale 1ns / 1ps
// Testbench for the ASCII string to integer parser: streams zero-terminated strings
// through the character channel and checks every parsed value and status it returns.
// Depends on asip_pkg, asip_char_if, asip_result_if and ascii_string_to_integer_parser_unit.

module ascii_string_to_integer_parser_unit_test;
    import asip_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;
    localparam int PHASE_ITEMS    = 82;
    localparam int SETTLE_CYCLES  = 3;
    localparam int DIGIT_INVALID  = 99;

    // Radix settings that the parser must reject.
    localparam logic [RADIX_BITS-1:0] RADIX_BAD_ONE = 5'd1;
    localparam logic [RADIX_BITS-1:0] RADIX_BAD_MID = 5'd17;
    localparam logic [RADIX_BITS-1:0] RADIX_BAD_TOP = 5'd31;

    // Uppercase prefix letters, which must not be taken as prefixes.
    localparam logic [CHAR_BITS-1:0] CH_UP_B = 8'h42;
    localparam logic [CHAR_BITS-1:0] CH_UP_X = 8'h58;

    // Radix used in each random phase, extremes and invalid settings among them.
    localparam logic [RADIX_BITS-1:0] RADIX_PLAN [13] = '{
        RADIX_16, RADIX_2, RADIX_8, RADIX_10, RADIX_BAD_TOP, RADIX_AUTO, RADIX_BAD_ONE,
        RADIX_16, RADIX_BAD_MID, RADIX_10, RADIX_AUTO, RADIX_2, RADIX_AUTO
    };

    // Tracks the parse of the current string and holds the results still owed.
    class parse_scoreboard;
        t_phase                 phase;
        logic                   minus;
        logic [RADIX_BITS-1:0]  base;
        logic [RADIX_BITS-1:0]  radix_reg;
        logic [VALUE_BITS-1:0]  total;
        logic [RESULT_BITS-1:0] value_due[$];
        logic                   status_due[$];
        int                     errors;
        int                     results_seen;

        function new();
            radix_reg    = RADIX_AUTO;
            errors       = 0;
            results_seen = 0;
            restart();
        endfunction

        function void restart();
            phase = PH_SKIP;
            minus = 1'b0;
            base  = RADIX_AUTO;
            total = '0;
        endfunction

        function void set_radix(input logic [RADIX_BITS-1:0] r);
            radix_reg = r;
        endfunction

        function int pending();
            return value_due.size();
        endfunction

        static function bit base_supported(input logic [RADIX_BITS-1:0] r);
            case (r) inside
                RADIX_AUTO, RADIX_2, RADIX_8, RADIX_10, RADIX_16: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        // Value of a character as a digit in any base up to 36.
        function int char_weight(input logic [CHAR_BITS-1:0] c);
            if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
            if (c >= CH_UP_A && c <= CH_UP_Z) return int'(c - CH_UP_A) + 10;
            if (c >= CH_LO_A && c <= CH_LO_Z) return int'(c - CH_LO_A) + 10;
            return DIGIT_INVALID;
        endfunction

        function void take_digit(input logic [CHAR_BITS-1:0] c);
            int w;
            w = char_weight(c);
            if (w < int'(base)) begin
                total = total * VALUE_BITS'(base) + VALUE_BITS'(w);
                phase = PH_DIGITS;
            end else begin
                phase = PH_DONE;
            end
        endfunction

        // First character after the blanks or the sign; a leading zero may open a prefix.
        function void take_first(input logic [CHAR_BITS-1:0] c);
            if (base == RADIX_AUTO) begin
                if (c == CH_ZERO) begin
                    total = '0;
                    phase = PH_ZERO;
                    return;
                end
                base = RADIX_10;
            end
            take_digit(c);
        endfunction

        // Called for every accepted character transaction.
        function void take_char(input logic [CHAR_BITS-1:0] c);
            logic [RESULT_BITS-1:0] v;
            if (phase == PH_SKIP) base = radix_reg;
            if (c == CH_NUL) begin
                if (!base_supported(base)) begin
                    value_due.push_back('0);
                    status_due.push_back(STATUS_BAD_RADIX);
                end else begin
                    v = minus ? (~total + 1'b1) : total;
                    value_due.push_back(v);
                    status_due.push_back(STATUS_OK);
                end
                restart();
                return;
            end
            case (phase)
                PH_SKIP: begin
                    // Control bytes, the space and bytes with the top bit set are blanks.
                    if (c > CH_SPACE && !c[CHAR_BITS-1]) begin
                        if (!base_supported(base)) begin
                            phase = PH_DONE;
                        end else if (c == CH_PLUS) begin
                            phase = PH_SIGNED;
                        end else if (c == CH_MINUS) begin
                            minus = 1'b1;
                            phase = PH_SIGNED;
                        end else begin
                            take_first(c);
                        end
                    end
                end
                PH_SIGNED: begin
                    take_first(c);
                end
                PH_ZERO: begin
                    if (c == CH_LO_B) begin
                        base  = RADIX_2;
                        phase = PH_DIGITS;
                    end else if (c == CH_LO_O) begin
                        base  = RADIX_8;
                        phase = PH_DIGITS;
                    end else if (c == CH_LO_X) begin
                        base  = RADIX_16;
                        phase = PH_DIGITS;
                    end else begin
                        base = RADIX_10;
                        take_digit(c);
                    end
                end
                PH_DIGITS: begin
                    take_digit(c);
                end
                default: begin
                    phase = PH_DONE;
                end
            endcase
        endfunction

        // Called for every accepted result transaction.
        function void check_result(input logic [RESULT_BITS-1:0] v, input logic s);
            logic [RESULT_BITS-1:0] exp_v;
            logic                   exp_s;
            results_seen++;
            if (value_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual value %h status %b",
                         $time, v, s);
                return;
            end
            exp_v = value_due.pop_front();
            exp_s = status_due.pop_front();
            if (v !== exp_v) begin
                errors++;
                $display("%0t: parsed_value mismatch, expected %h, actual %h", $time, exp_v, v);
            end
            if (s !== exp_s) begin
                errors++;
                $display("%0t: status_code mismatch, expected %b, actual %b", $time, exp_s, s);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_wr_en;
    logic [RADIX_BITS-1:0] cfg_wr_data;

    asip_char_if   char_bus ();
    asip_result_if result_bus ();

    ascii_string_to_integer_parser_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_char        (char_bus),
        .o_result      (result_bus)
    );

    parse_scoreboard      board;
    logic [CHAR_BITS-1:0] text_buf[$];
    bit                   no_idle = 1'b0;
    int                   items_sent = 0;
    int                   idle_cycles = 0;
    int                   long_holds = 0;

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CHAR_BITS-1:0] digit_char(input int d);
        if (d < 10) return CH_ZERO + 8'(d);
        return ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + 8'(d - 10);
    endfunction

    // Characters that sit on the edges of the parse: signs, prefixes, blanks, last digits.
    function automatic logic [CHAR_BITS-1:0] tricky_char();
        case ($urandom_range(0, 11))
            0: return CH_SPACE;
            1: return CH_PLUS;
            2: return CH_MINUS;
            3: return CH_ZERO;
            4: return CH_LO_B;
            5: return CH_LO_O;
            6: return CH_LO_X;
            7: return CH_UP_X;
            8: return CH_UP_B;
            9: return CH_NINE;
            10: return $urandom_range(0, 1) ? CH_UP_Z : CH_LO_Z;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // Monitors: both channels are sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && char_bus.valid && char_bus.ready) begin
            board.take_char(char_bus.char_code);
        end
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            board.check_result(result_bus.parsed_value, result_bus.status_code);
        end
    end

    // Watchdog: ends the run when no transaction has happened for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (char_bus.valid && char_bus.ready) ||
            (result_bus.valid && result_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result receiver: bursts of ready with random stalls, and one long hold-off
    // so that the result register fills and the character input backs up.
    initial begin
        int run_len;
        int stall;
        result_bus.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            run_len = $urandom_range(1, 40);
            result_bus.ready <= 1'b1;
            repeat (run_len) @(negedge i_clk);
            if (long_holds == 0 && board.results_seen >= 30) begin
                stall = LONG_HOLD;
                long_holds++;
            end else begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
        end
    end

    // Offers one character and returns at the falling edge after it was accepted.
    task automatic send_char(input logic [CHAR_BITS-1:0] c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            char_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        char_bus.valid     <= 1'b1;
        char_bus.char_code <= c;
        do @(posedge i_clk); while (!char_bus.ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    // Sends the buffered string followed by its terminating zero byte.
    task automatic send_text();
        text_buf.push_back(CH_NUL);
        foreach (text_buf[i]) send_char(text_buf[i]);
        text_buf.delete();
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endtask

    // Waits until every owed result has arrived and the block has gone quiet.
    task automatic settle();
        char_bus.valid <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_radix(input logic [RADIX_BITS-1:0] r);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= r;
        @(negedge i_clk);
        cfg_wr_en   <= 1'b0;
        board.set_radix(r);
    endtask

    // Builds one random string: mostly well-formed numbers, some noise, some broken forms.
    task automatic build_random_text(input logic [RADIX_BITS-1:0] radix);
        int style;
        int n;
        int digits;
        int b;
        style = $urandom_range(0, 99);
        text_buf.delete();
        if (style < 80) begin
            if ($urandom_range(0, 9) < 4) begin
                n = $urandom_range(1, 3);
                repeat (n) begin
                    text_buf.push_back($urandom_range(0, 1) ? 8'($urandom_range(1, 32))
                                                           : 8'($urandom_range(128, 255)));
                end
            end
            case ($urandom_range(0, 2))
                1: text_buf.push_back(CH_PLUS);
                2: text_buf.push_back(CH_MINUS);
                default: ;
            endcase
            b = 10;
            if (radix == RADIX_AUTO) begin
                case ($urandom_range(0, 3))
                    1: begin
                        add_text("0b");
                        b = 2;
                    end
                    2: begin
                        add_text("0o");
                        b = 8;
                    end
                    3: begin
                        add_text("0x");
                        b = 16;
                    end
                    default: ;
                endcase
            end else if (parse_scoreboard::base_supported(radix)) begin
                b = int'(radix);
            end
            // A few long digit runs wrap the total round.
            digits = ($urandom_range(0, 99) < 15) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            repeat (digits) text_buf.push_back(digit_char($urandom_range(0, b - 1)));
            if ($urandom_range(0, 9) < 3) begin
                n = $urandom_range(1, 3);
                repeat (n) text_buf.push_back(8'($urandom_range(1, 255)));
            end
        end else if (style < 92) begin
            n = $urandom_range(0, 8);
            repeat (n) text_buf.push_back(8'($urandom_range(1, 255)));
        end else begin
            n = $urandom_range(1, 6);
            repeat (n) text_buf.push_back(tricky_char());
        end
    endtask

    // Main sequence: reset, directed strings, then random phases under several radix settings.
    initial begin
        int start;
        board               = new();
        i_rst_n             = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = RADIX_AUTO;
        char_bus.valid      = 1'b0;
        char_bus.char_code  = CH_NUL;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Every kind of blank, a minus sign, a hex prefix and hex letters in both cases.
        text_buf = '{8'h01, CH_SPACE, 8'h80, 8'hFF};
        add_text("-0xFf");
        send_text();
        // Uppercase prefix letter ends the digits.
        add_text("+0B1");
        send_text();
        // A blank after the sign ends the digits.
        add_text("- 5");
        send_text();
        // Empty string.
        send_text();
        // A byte with the top bit set after the digits ends them.
        add_text("7");
        text_buf.push_back(8'hC8);
        add_text("3");
        send_text();

        foreach (RADIX_PLAN[p]) begin
            settle();
            write_radix(RADIX_PLAN[p]);
            no_idle = (p % 5 == 3);
            start   = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                build_random_text(RADIX_PLAN[p]);
                send_text();
            end
        end
        no_idle = 1'b0;

        settle();
        repeat (4) @(negedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/asip_pkg.sv
hw/rtl/asip_char_if.sv
hw/rtl/asip_result_if.sv
hw/rtl/ascii_string_to_integer_parser_unit.sv
tb/ascii_string_to_integer_parser_unit_test.sv
